// ----- rtl/lzce_pkg.sv -----
`default_nettype none
package lzce_pkg;

	localparam int FW_BITS   = 11;
	localparam int FH_BITS   = 13;
	localparam int CFG_BITS  = 13;
	localparam int IDX_BITS  = 2;
	localparam int ROW_BITS  = 13;
	localparam int PIX_BITS  = 8;
	localparam int LAP_BITS  = 11;
	localparam int MIN_DIM   = 3;
	localparam int MAX_ROWS  = 4096;

	localparam logic [FW_BITS-1:0]  RESET_WIDTH  = 11'd640;
	localparam logic [FH_BITS-1:0]  RESET_HEIGHT = 13'd480;
	localparam logic [PIX_BITS-1:0] EDGE_MARK    = 8'd255;
	localparam logic [PIX_BITS-1:0] NO_MARK      = 8'd0;

	localparam logic [IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;

	typedef logic signed [LAP_BITS-1:0] lap_t;
	typedef logic [PIX_BITS-1:0] pix_t;

	typedef struct packed {
		pix_t mark;
		logic valid;
		logic last;
	} result_t;

	function automatic logic opposite(input lap_t p, input lap_t q);
		opposite = ((p < 0) && (q > 0)) || ((p > 0) && (q < 0));
	endfunction

endpackage
`default_nettype wire

// ----- rtl/laplacian_zero_crossing_edges_top.sv -----
// An accepted item's result is registered in the result register or the skid stage;
// the mark of a pixel arrives with the item two rows plus two pixels after it.
// Throughput: one item per cycle unless stalled, set by the one registered window pass.
// A one-entry skid stage behind the result register takes one more item once the output
// stalls; the input stalls after that until the output drains.
// Reset clears counters, windows, handshake state and the config to its defaults;
// result data and line memories are not cleared and no clearing pass runs.
`default_nettype none
module laplacian_zero_crossing_edges_top #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire [lzce_pkg::IDX_BITS-1:0]   cfg_index,
	input  wire [lzce_pkg::CFG_BITS-1:0]   cfg_data,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire                            op,
	input  wire [lzce_pkg::PIX_BITS-1:0]   pixel,
	output logic                           res_valid,
	input  wire                            res_stall,
	output logic [lzce_pkg::PIX_BITS-1:0]  mark,
	output logic                           out_valid,
	output logic                           out_last
);
	import lzce_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);

	logic [FW_BITS-1:0] frame_width_q;
	logic [FH_BITS-1:0] frame_height_q;
	logic [WW-1:0] w;
	logic [ROW_BITS-1:0] h;
	logic [CW-1:0] col_q, col_next, col_d, b, b_d;
	logic [ROW_BITS-1:0] row_q;
	logic col_wrap;

	pix_t p_up_q, p_left_q, p_mid_q, p_down_q;
	lap_t l01_q, l02_q, l11_q, l12_q, l21_q, l22_q;

	logic [2*PIX_BITS-1:0] prd;
	logic [2*LAP_BITS-1:0] lrd;
	pix_t px, pr0, pr1;
	lap_t lr0, lr1, lap;

	logic accept, cfg_restart, restart, lap_en;
	result_t res_new, out_q, skid_q;
	logic skid_valid_q, out_free;
	logic new_mark;

	always_comb begin
		if (frame_width_q < FW_BITS'(MIN_DIM)) begin
			w = WW'(MIN_DIM);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			w = WW'(MAX_WIDTH);
		end else begin
			w = WW'(frame_width_q);
		end
		if (frame_height_q < FH_BITS'(MIN_DIM)) begin
			h = ROW_BITS'(MIN_DIM);
		end else if (32'(frame_height_q) > MAX_ROWS) begin
			h = ROW_BITS'(MAX_ROWS);
		end else begin
			h = ROW_BITS'(frame_height_q);
		end
	end

	assign in_stall = skid_valid_q;
	assign accept = in_valid && !skid_valid_q;
	assign cfg_restart = cfg_we &&
		((cfg_index == CFG_FRAME_WIDTH) || (cfg_index == CFG_FRAME_HEIGHT));
	assign restart = cfg_restart || (accept && res_new.last);

	assign col_wrap = (WW'({1'b0, col_q}) + WW'(1)) >= w;
	assign col_next = col_wrap ? '0 : col_q + CW'(1);
	assign b = (col_q == '0) ? CW'(w - WW'(1)) : col_q - CW'(1);

	always_comb begin
		if (restart) begin
			col_d = '0;
		end else if (accept) begin
			col_d = col_next;
		end else begin
			col_d = col_q;
		end
		b_d = (col_d == '0) ? CW'(w - WW'(1)) : col_d - CW'(1);
	end

	assign px = op ? '0 : pixel;
	assign pr0 = prd[PIX_BITS-1:0];
	assign pr1 = prd[2*PIX_BITS-1:PIX_BITS];
	assign lr0 = lrd[LAP_BITS-1:0];
	assign lr1 = lrd[2*LAP_BITS-1:LAP_BITS];

	lzce_line_ram #(.DATA_W(2 * PIX_BITS), .DEPTH(MAX_WIDTH)) u_pixel_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata ({pr0, px}),
		.raddr (col_d),
		.rdata (prd)
	);

	lzce_line_ram #(.DATA_W(2 * LAP_BITS), .DEPTH(MAX_WIDTH)) u_laplace_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (b),
		.wdata ({lr0, lap}),
		.raddr (b_d),
		.rdata (lrd)
	);

	// The Laplacian is formed only at interior positions; elsewhere it is zero.
	assign lap_en = (col_q >= CW'(2)) && (row_q >= ROW_BITS'(2)) &&
		(row_q <= h - ROW_BITS'(1));

	always_comb begin
		lap = '0;
		if (lap_en) begin
			lap = lap_t'({3'b000, p_up_q}) + lap_t'({3'b000, p_down_q})
				+ lap_t'({3'b000, p_left_q}) + lap_t'({3'b000, pr0})
				- lap_t'({1'b0, p_mid_q, 2'b00});
		end
	end

	always_comb begin
		res_new.valid = 1'b0;
		res_new.last = 1'b0;
		new_mark = 1'b0;
		if (col_q >= CW'(2)) begin
			res_new.valid = (row_q >= ROW_BITS'(2)) && (row_q <= h + ROW_BITS'(1));
			new_mark = (col_q >= CW'(3)) && (row_q >= ROW_BITS'(3)) && (row_q <= h);
		end else begin
			res_new.valid = (row_q >= ROW_BITS'(3)) && (row_q <= h + ROW_BITS'(2));
			if (col_q == '0) begin
				new_mark = (row_q >= ROW_BITS'(4)) && (row_q <= h + ROW_BITS'(1));
			end else begin
				res_new.last = (row_q == h + ROW_BITS'(2));
			end
		end
		new_mark = new_mark && (l12_q <= 0) &&
			(opposite(l02_q, l22_q) || opposite(l11_q, lr0) ||
			 opposite(l01_q, lap) || opposite(lr1, l21_q));
		res_new.mark = new_mark ? EDGE_MARK : NO_MARK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= RESET_WIDTH;
			frame_height_q <= RESET_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH: frame_width_q <= cfg_data[FW_BITS-1:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			p_up_q <= '0;
			p_left_q <= '0;
			p_mid_q <= '0;
			p_down_q <= '0;
			l01_q <= '0;
			l02_q <= '0;
			l11_q <= '0;
			l12_q <= '0;
			l21_q <= '0;
			l22_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
			p_up_q <= '0;
			p_left_q <= '0;
			p_mid_q <= '0;
			p_down_q <= '0;
			l01_q <= '0;
			l02_q <= '0;
			l11_q <= '0;
			l12_q <= '0;
			l21_q <= '0;
			l22_q <= '0;
		end else if (accept) begin
			col_q <= col_next;
			if (col_wrap) begin
				row_q <= row_q + ROW_BITS'(1);
			end
			p_up_q <= pr1;
			p_left_q <= p_mid_q;
			p_mid_q <= pr0;
			p_down_q <= px;
			l01_q <= l02_q;
			l02_q <= lr1;
			l11_q <= l12_q;
			l12_q <= lr0;
			l21_q <= l22_q;
			l22_q <= lap;
		end
	end

	assign out_free = !res_valid || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				res_valid <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				res_valid <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res_new;
			end
		end else if (accept) begin
			skid_q <= res_new;
		end
	end

	assign mark = out_q.mark;
	assign out_valid = out_q.valid;
	assign out_last = out_q.last;

endmodule
`default_nettype wire

// ----- rtl/lzce_line_ram.sv -----
`default_nettype none
module lzce_line_ram #(
	parameter int DATA_W = 16,
	parameter int DEPTH = 1024
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [DATA_W-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire
